>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising edge, skipped while reset is low.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/ilfsa_pkg.sv
package ilfsa_pkg;

    localparam int NUM_SLOTS  = 64;
    localparam int TIME_BITS  = 32;

    // Port field widths (fixed by the item format)
    localparam int START_W    = 32;
    localparam int END_W      = 32;
    localparam int GRANT_W    = 6;
    localparam int BUSY_W     = 7;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 16;

    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W      = $clog2(NUM_SLOTS + 1);

    // Busy-count tree: groups of eight slots counted, then the group sums added
    localparam int GRP_SIZE   = 8;
    localparam int NUM_GRPS   = (NUM_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int GRP_CNT_W  = $clog2(GRP_SIZE + 1);
    localparam int PAD_SLOTS  = NUM_GRPS * GRP_SIZE;

    typedef logic [TIME_BITS-1:0]  t_time;
    typedef logic [SLOT_IDX_W-1:0] t_slot_idx;
    typedef logic [NUM_SLOTS-1:0]  t_slot_vec;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [GRP_CNT_W-1:0]  t_grp_cnt;

endpackage

>>> hdl/interval_lowest_free_slot_allocator_top.sv
// Interval lowest-free-slot allocator.
//
// Input stream (s_axis): one interval per transfer; tdata carries start_time
// and end_time, tuser the new_batch flag. Intervals are expected in order of
// non-decreasing start. Output stream (m_axis): exactly one result per
// interval, in order: the granted slot, the busy-slot count after the step and
// a no_free_slot flag in tuser.
//
// Each interval frees every busy slot whose stored end lies strictly below its
// start (all slots when new_batch is set), then claims the lowest free slot.
// Stages: A input register, B grant, C per-group busy counts, D output
// register. Throughput is one interval per cycle while m_axis does not
// stall: the slot update is a combinational compare of all 64 stored ends plus
// a priority encoder, and the busy count runs two pipeline stages behind it.
//
// Reset (synchronous, active low) marks all slots free and empties the
// pipeline. When the receiver stalls, results stay in the pipeline; inputs
// keep being taken until every stage is occupied, then s_axis_tready drops.
module interval_lowest_free_slot_allocator_top
    import ilfsa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input intervals
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,   // [31:0] start_time, [63:32] end_time
    input  logic                i_s_axis_tuser,   // [0] new_batch
    // results
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [M_DATA_W-1:0] o_m_axis_tdata,   // [5:0] granted_slot, [12:6] slots_busy,
                                                  // [15:13] zero
    output logic                o_m_axis_tuser    // [0] no_free_slot
);

`include "assert_macros.svh"

    // ---------------- slot state ----------------
    t_slot_vec r_busy;
    t_time     r_end [NUM_SLOTS];

    // ---------------- stage A: input register ----------------
    logic      r_a_valid;
    t_time     r_a_start;
    t_time     r_a_end;
    logic      r_a_batch;

    // ---------------- stage B: grant result ----------------
    logic      r_b_valid;
    t_slot_idx r_b_pick;
    logic      r_b_nofree;

    // ---------------- stage C: per-group busy counts ----------------
    logic      r_c_valid;
    t_slot_idx r_c_pick;
    logic      r_c_nofree;
    t_grp_cnt  r_c_grp [NUM_GRPS];

    // ---------------- stage D: output register ----------------
    logic      r_d_valid;
    t_slot_idx r_d_pick;
    logic      r_d_nofree;
    t_cnt      r_d_cnt;

    // Each stage takes new data when it is empty or its content moves on
    logic rdy_a, rdy_b, rdy_c, rdy_d;
    logic adv_in, adv_a, adv_b, adv_c;

    assign rdy_d  = !r_d_valid || i_m_axis_tready;
    assign rdy_c  = !r_c_valid || rdy_d;
    assign rdy_b  = !r_b_valid || rdy_c;
    assign rdy_a  = !r_a_valid || rdy_b;

    assign adv_in = i_s_axis_tvalid && rdy_a;
    assign adv_a  = r_a_valid && rdy_b;
    assign adv_b  = r_b_valid && rdy_c;
    assign adv_c  = r_c_valid && rdy_d;

    assign o_s_axis_tready = rdy_a;

    // ---------------- release and grant ----------------
    t_slot_vec keep;
    t_slot_vec n_busy;
    t_slot_idx pick;
    logic      found;

    always_comb begin
        // slot stays busy unless the batch restarts or its end fell behind start
        for (int i = 0; i < NUM_SLOTS; i++) begin
            keep[i] = r_busy[i] && !r_a_batch && !(r_end[i] < r_a_start);
        end
        // lowest free slot wins
        pick  = '0;
        found = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!keep[i]) begin
                pick  = SLOT_IDX_W'(i);
                found = 1'b1;
            end
        end
        n_busy = keep;
        if (found) begin
            n_busy[pick] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else if (adv_a) begin
            r_busy <= n_busy;
        end
    end

    // stored ends: the compare result counts only for entries with their busy bit set
    always_ff @(posedge i_clk) begin
        if (adv_a && found) begin
            r_end[pick] <= r_a_end;
        end
    end

    // ---------------- group counts ----------------
    // r_busy holds the state left by the item in stage B whenever B is valid.
    logic [PAD_SLOTS-1:0] busy_pad;
    t_grp_cnt             grp_cnt [NUM_GRPS];

    assign busy_pad = PAD_SLOTS'(r_busy);

    always_comb begin
        for (int g = 0; g < NUM_GRPS; g++) begin
            grp_cnt[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++) begin
                grp_cnt[g] = grp_cnt[g] + GRP_CNT_W'(busy_pad[g*GRP_SIZE + k]);
            end
        end
    end

    t_cnt cnt_sum;

    always_comb begin
        cnt_sum = '0;
        for (int g = 0; g < NUM_GRPS; g++) begin
            cnt_sum = cnt_sum + CNT_W'(r_c_grp[g]);
        end
    end

    // ---------------- pipeline valids ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_valid <= i_s_axis_tvalid;
            end
            if (rdy_b) begin
                r_b_valid <= r_a_valid;
            end
            if (rdy_c) begin
                r_c_valid <= r_b_valid;
            end
            if (rdy_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    // ---------------- pipeline payload ----------------
    always_ff @(posedge i_clk) begin
        if (adv_in) begin
            r_a_start <= TIME_BITS'(i_s_axis_tdata[START_W-1:0]);
            r_a_end   <= TIME_BITS'(i_s_axis_tdata[START_W +: END_W]);
            r_a_batch <= i_s_axis_tuser;
        end
        if (adv_a) begin
            r_b_pick   <= pick;
            r_b_nofree <= !found;
        end
        if (adv_b) begin
            r_c_pick   <= r_b_pick;
            r_c_nofree <= r_b_nofree;
            r_c_grp    <= grp_cnt;
        end
        if (adv_c) begin
            r_d_pick   <= r_c_pick;
            r_d_nofree <= r_c_nofree;
            r_d_cnt    <= cnt_sum;
        end
    end

    // ---------------- outputs ----------------
    assign o_m_axis_tvalid = r_d_valid;
    assign o_m_axis_tuser  = r_d_nofree;
    assign o_m_axis_tdata  = {(M_DATA_W - GRANT_W - BUSY_W)'(0),
                              BUSY_W'(r_d_cnt),
                              GRANT_W'(r_d_pick)};

    // ---------------- assertions ----------------
    `ASSERT_AT(a_grant_is_busy, i_clk, i_rst_n,
        (r_b_valid && !r_b_nofree) |-> r_busy[r_b_pick],
        "granted slot not marked busy")

    `ASSERT_AT(a_overflow_all_busy, i_clk, i_rst_n,
        (r_b_valid && r_b_nofree) |-> (&r_busy),
        "overflow reported while a slot is free")

    `ASSERT_AT(a_overflow_full_count, i_clk, i_rst_n,
        (r_d_valid && r_d_nofree) |-> (r_d_cnt == CNT_W'(NUM_SLOTS)),
        "overflow result with busy count below slot total")

    `ASSERT_ALWAYS(a_reset_clears, i_clk,
        !i_rst_n |=> (r_busy == '0 && !r_a_valid && !r_d_valid),
        "reset did not free slots or empty pipeline")

endmodule

>>> sim/tb_interval_lowest_free_slot_allocator_top.sv
`timescale 1ns / 1ps

module tb_interval_lowest_free_slot_allocator_top;
    import ilfsa_pkg::*;

    // One result as it appears on m_axis, unpacked into its fields.
    typedef struct packed {
        logic [GRANT_W-1:0] slot;
        logic               full;
        logic [BUSY_W-1:0]  busy;
    } t_grant;

    // One row of the directed table: interval, batch flag, and an optional
    // hand-written result (only where it is obvious from the rules).
    typedef struct packed {
        logic [START_W-1:0] start_t;
        logic [END_W-1:0]   end_t;
        logic               batch;
        logic               typed;
        t_grant             res;
    } t_interval_row;

    localparam int NUM_ROWS     = 17;
    localparam int PHASE_ITEMS  = 350;
    localparam int DRAIN_CYCLES = 8;

    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_s_axis_tvalid  = 1'b0;
    logic                o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata   = '0;  // [31:0] start_time, [63:32] end_time
    logic                i_s_axis_tuser   = 1'b0; // [0] new_batch
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready  = 1'b0;
    logic [M_DATA_W-1:0] o_m_axis_tdata;          // [5:0] granted_slot, [12:6] slots_busy
    logic                o_m_axis_tuser;          // [0] no_free_slot

    // Idle rates in percent for the sender and the receiver.
    int src_idle_pct = 27;
    int snk_idle_pct = 72;
    int check_errors = 0;

    // Shadow copy of the slot table and the results still owed by the block.
    logic   slot_taken    [NUM_SLOTS] = '{default: 1'b0};
    t_time  slot_deadline [NUM_SLOTS] = '{default: '0};
    t_grant pending_grants [$];

    // Directed table: after reset, time extremes, batch clear, end below
    // start, start out of order, alternating bit patterns.
    t_interval_row dir_rows [NUM_ROWS] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, '{6'd0, 1'b0, 7'd1}},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, '{6'd1, 1'b0, 7'd2}},
        '{32'h0000_0001, 32'h0000_0005, 1'b0, 1'b1, '{6'd0, 1'b0, 7'd2}},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, '{6'd0, 1'b0, 7'd2}},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1, '{6'd2, 1'b0, 7'd3}},
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, '{6'd0, 1'b0, 7'd1}},
        '{32'h0000_000A, 32'h0000_0003, 1'b0, 1'b1, '{6'd0, 1'b0, 7'd1}},
        '{32'h0000_0003, 32'h0000_0014, 1'b0, 1'b1, '{6'd1, 1'b0, 7'd2}},
        '{32'h0000_0004, 32'h0000_0014, 1'b0, 1'b1, '{6'd0, 1'b0, 7'd2}},
        '{32'h0000_0015, 32'h0000_0007, 1'b0, 1'b1, '{6'd0, 1'b0, 7'd1}},
        '{32'h0000_0008, 32'h8000_0000, 1'b0, 1'b1, '{6'd0, 1'b0, 7'd1}},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, '0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b0, '0},
        '{32'h1234_5678, 32'hFEDC_BA98, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFE, 32'h0000_0001, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, '0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, '0}
    };

    interval_lowest_free_slot_allocator_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Release busy slots that ended strictly before the new start, then claim
    // the lowest free slot; report an overflow when none is left.
    function automatic t_grant alloc_predict(input t_time start_t, input t_time end_t,
                                             input logic batch);
        t_grant res;
        int     count;
        bit     found;
        res   = '0;
        count = 0;
        found = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (batch || (slot_taken[i] && slot_deadline[i] < start_t))
                slot_taken[i] = 1'b0;
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!found && !slot_taken[i]) begin
                found            = 1'b1;
                res.slot         = GRANT_W'(i);
                slot_taken[i]    = 1'b1;
                slot_deadline[i] = end_t;
            end
        end
        for (int i = 0; i < NUM_SLOTS; i++)
            count += slot_taken[i];
        res.full = !found;
        res.busy = BUSY_W'(count);
        return res;
    endfunction

    // Drive one interval and hold it until the transfer; keep tvalid high when
    // no gap follows so back-to-back transfers never toggle it in one step.
    task automatic send_interval(input t_time start_t, input t_time end_t, input logic batch,
                                 input logic typed, input t_grant typed_res);
        t_grant pred;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {end_t, start_t};
        i_s_axis_tuser  <= batch;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pred = alloc_predict(start_t, end_t, batch);
        pending_grants.push_back(typed ? typed_res : pred);
    endtask

    // Stop sending and wait until the block has returned every result.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge i_clk);
    endtask

    // Mostly well-formed batches: a batch flag on the first interval, starts
    // rising in small steps. Dense batches hold long ends so the slots fill
    // up and overflow; short ones recycle slots. A few items are pure noise
    // or step the start backwards.
    task automatic run_random(input int num_items, input bit force_dense);
        int          sent;
        int          len;
        bit          dense;
        t_time       cur_start;
        int unsigned dur;
        sent = 0;
        while (sent < num_items) begin
            if (!force_dense && $urandom_range(99) < 8) begin
                send_interval($urandom, $urandom, 1'($urandom_range(1)), 1'b0, '0);
                sent++;
            end else begin
                dense     = force_dense || ($urandom_range(3) == 0);
                len       = force_dense ? 80 : $urandom_range(5, 80);
                cur_start = $urandom;
                for (int j = 0; j < len && sent < num_items; j++) begin
                    if ($urandom_range(31) == 0)
                        cur_start -= $urandom_range(1, 50);
                    else
                        cur_start += $urandom_range(0, 3);
                    if ($urandom_range(15) == 0)
                        dur = $urandom;
                    else if (dense)
                        dur = $urandom_range(200, 5000);
                    else
                        dur = $urandom_range(0, 40);
                    send_interval(cur_start, cur_start + dur, j == 0, 1'b0, '0);
                    sent++;
                end
                force_dense = 1'b0;
            end
        end
    endtask

    // Receiver: drop tready at the current idle rate.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Compare each result transfer with the oldest pending prediction.
    always @(posedge i_clk) begin
        t_grant exp_res;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_grants.size() == 0) begin
                $error("result transfer with no interval pending");
                check_errors++;
            end else begin
                exp_res = pending_grants.pop_front();
                if (o_m_axis_tdata[5:0] !== exp_res.slot) begin
                    $error("granted_slot: expected %0d, got %0d",
                           exp_res.slot, o_m_axis_tdata[5:0]);
                    check_errors++;
                end
                if (o_m_axis_tdata[12:6] !== exp_res.busy) begin
                    $error("slots_busy: expected %0d, got %0d",
                           exp_res.busy, o_m_axis_tdata[12:6]);
                    check_errors++;
                end
                if (o_m_axis_tuser !== exp_res.full) begin
                    $error("no_free_slot: expected %0d, got %0d",
                           exp_res.full, o_m_axis_tuser);
                    check_errors++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, then a forced dense batch to hit the overflow early.
        for (int r = 0; r < NUM_ROWS; r++)
            send_interval(dir_rows[r].start_t, dir_rows[r].end_t, dir_rows[r].batch,
                          dir_rows[r].typed, dir_rows[r].res);
        run_random(PHASE_ITEMS - NUM_ROWS, 1'b1);
        drain_results();

        // Swap the idle rates, then run with no idling at all.
        src_idle_pct = 72;
        snk_idle_pct = 27;
        run_random(PHASE_ITEMS, 1'b0);
        drain_results();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(PHASE_ITEMS, 1'b0);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (check_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
